/* hdl/fbsc_pkg.sv */
// ---------------------------------------------------------------------------
// fbsc_pkg
// Types and constants shared by the FAT16 boot sector check pipeline.
// ---------------------------------------------------------------------------
package fbsc_pkg;

  localparam logic [15:0] SectorBytes  = 16'd512;
  // entries * 32 / 512 is a right shift by four
  localparam int          DirShift     = 4;
  localparam int          TotalWidth   = 32;
  localparam int          DivisorWidth = 8;
  localparam int          DivBits      = 8;
  localparam int          DivStages    = TotalWidth / DivBits;
  localparam logic [TotalWidth-1:0] MinClusters  = 32'd4085;
  localparam logic [TotalWidth-1:0] ClusterLimit = 32'd65525;
  // "FAT16   " and "FAT12   ", byte 0 in the low bits
  localparam logic [63:0] LabelFat16   = 64'h2020_2036_3154_4146;
  localparam logic [63:0] LabelFat12   = 64'h2020_2032_3154_4146;

  typedef struct packed {
    logic [15:0] sector_size;
    logic [7:0]  cluster_secs;
    logic [15:0] rsvd_secs;
    logic [7:0]  fat_copies;
    logic [15:0] root_entries;
    logic [15:0] small_total;
    logic [31:0] large_total;
    logic [15:0] sectors_per_fat;
    logic [63:0] type_label;
  } fbsc_in_t;

  typedef struct packed {
    logic        status;
    logic [15:0] fat_start_sector;
    logic [11:0] root_dir_sector_count;
    logic [17:0] first_data_sector;
    logic [15:0] cluster_count;
  } fbsc_out_t;

  // layout and check result that rides along with the division
  typedef struct packed {
    logic        ok;
    logic [15:0] fat_start;
    logic [11:0] root_secs;
    logic [17:0] first_data;
  } fbsc_layout_t;

endpackage

/* hdl/fat16_boot_sector_check_core.sv */
// ---------------------------------------------------------------------------
// fat16_boot_sector_check_core
// Boot sector parameter check and FAT12/FAT16 volume layout.
// ---------------------------------------------------------------------------
// Takes one beat of parsed boot sector fields per clock while in_stall_o is
// low and returns one result beat per input, in order. Between acceptance
// and out_valid_o lie two stages for the field checks, layout sum and
// data region size, four stages of the 32-bit by 8-bit cluster divider
// (eight quotient bits each), and the output register with the cluster
// range check. The pipeline keeps filling while a result waits on
// out_stall_i; in_stall_o rises only when every stage holds a beat.
// Invalid volumes return status 1 with all other fields zero.
module fat16_boot_sector_check_core import fbsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  fbsc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output fbsc_out_t out_data_o
);

  logic                    fr_ready;
  logic                    fr_valid;
  logic                    dv_ready;
  logic [TotalWidth-1:0]   fr_diff;
  logic [DivisorWidth-1:0] fr_spc;
  fbsc_layout_t            fr_layout;

  logic                    dv_valid;
  logic                    o_ready;
  logic [TotalWidth-1:0]   dv_quot;
  fbsc_layout_t            dv_layout;

  logic                    out_valid_q;
  fbsc_out_t               out_q, out_d;
  logic                    ok;

  fbsc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (fr_ready),
    .in_data_i    (in_data_i),
    .out_valid_o  (fr_valid),
    .out_ready_i  (dv_ready),
    .out_diff_o   (fr_diff),
    .out_spc_o    (fr_spc),
    .out_layout_o (fr_layout)
  );

  fbsc_div u_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (fr_valid),
    .in_ready_o     (dv_ready),
    .in_dividend_i  (fr_diff),
    .in_divisor_i   (fr_spc),
    .in_layout_i    (fr_layout),
    .out_valid_o    (dv_valid),
    .out_ready_i    (o_ready),
    .out_quotient_o (dv_quot),
    .out_layout_o   (dv_layout)
  );

  assign o_ready    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !fr_ready;

  always_comb begin
    ok = dv_layout.ok && (dv_quot >= MinClusters) && (dv_quot < ClusterLimit);
    if (ok) begin
      out_d.status                = 1'b0;
      out_d.fat_start_sector      = dv_layout.fat_start;
      out_d.root_dir_sector_count = dv_layout.root_secs;
      out_d.first_data_sector     = dv_layout.first_data;
      out_d.cluster_count         = dv_quot[15:0];
    end else begin
      out_d        = '0;
      out_d.status = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (o_ready) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && dv_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a valid volume always lands in the cluster range
  a_cluster_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.status |->
      out_data_o.cluster_count >= 16'd4085 && out_data_o.cluster_count <= 16'd65524)
    else $error("cluster count out of range on valid volume");

  // rejected volumes carry no layout
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |->
      out_data_o.fat_start_sector == '0 && out_data_o.root_dir_sector_count == '0 &&
      out_data_o.first_data_sector == '0 && out_data_o.cluster_count == '0)
    else $error("invalid result with nonzero fields");

  // data region starts past reserved and root directory sectors
  a_layout_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.status |->
      out_data_o.first_data_sector >
        ({2'd0, out_data_o.fat_start_sector} + {6'd0, out_data_o.root_dir_sector_count}))
    else $error("first data sector below fat and root regions");

  // upstream backpressure only when the output register is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

endmodule

/* hdl/fbsc_front.sv */
// ---------------------------------------------------------------------------
// fbsc_front
// Field checks, region layout and the data region size, in two stages.
// ---------------------------------------------------------------------------
module fbsc_front import fbsc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  fbsc_in_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [TotalWidth-1:0]   out_diff_o,
  output logic [DivisorWidth-1:0] out_spc_o,
  output fbsc_layout_t            out_layout_o
);

  // stage a: checks, total select, overhead sum
  logic                    a_valid_q;
  logic                    a_ok_q, a_ok_d;
  logic [TotalWidth-1:0]   a_total_q, a_total_d;
  logic [DivisorWidth-1:0] a_spc_q;
  logic [15:0]             a_rsv_q;
  logic [11:0]             a_rds_q, a_rds_d;
  logic [17:0]             a_ovh_q, a_ovh_d;
  logic                    a_ready;

  // stage b: data region size and overhead check
  logic                    b_valid_q;
  logic [TotalWidth-1:0]   b_diff_q, b_diff_d;
  logic [DivisorWidth-1:0] b_spc_q;
  fbsc_layout_t            b_layout_q, b_layout_d;
  logic                    b_ready;

  logic [17:0] fat_secs;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_comb begin
    a_ok_d = 1'b1;
    if (in_data_i.sector_size != SectorBytes) a_ok_d = 1'b0;
    if (in_data_i.cluster_secs == '0) a_ok_d = 1'b0;
    if (in_data_i.root_entries == '0) a_ok_d = 1'b0;
    if (in_data_i.fat_copies == 8'd0 || in_data_i.fat_copies > 8'd2) a_ok_d = 1'b0;
    if (in_data_i.sectors_per_fat == '0) a_ok_d = 1'b0;
    if (in_data_i.type_label != LabelFat16 && in_data_i.type_label != LabelFat12) begin
      a_ok_d = 1'b0;
    end
    a_total_d = (in_data_i.small_total != '0) ? {16'd0, in_data_i.small_total}
                                              : in_data_i.large_total;
    if (a_total_d == '0) a_ok_d = 1'b0;
    a_rds_d = in_data_i.root_entries[15:DirShift];
    // copy count other than one or two is already rejected
    fat_secs = (in_data_i.fat_copies == 8'd2) ? {1'b0, in_data_i.sectors_per_fat, 1'b0}
                                              : {2'd0, in_data_i.sectors_per_fat};
    a_ovh_d = {2'd0, in_data_i.rsvd_secs} + fat_secs + {6'd0, a_rds_d};
  end

  always_comb begin
    b_diff_d              = a_total_q - {14'd0, a_ovh_q};
    b_layout_d.ok         = a_ok_q && ({14'd0, a_ovh_q} < a_total_q);
    b_layout_d.fat_start  = a_rsv_q;
    b_layout_d.root_secs  = a_rds_q;
    b_layout_d.first_data = a_ovh_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_ok_q    <= a_ok_d;
      a_total_q <= a_total_d;
      a_spc_q   <= in_data_i.cluster_secs;
      a_rsv_q   <= in_data_i.rsvd_secs;
      a_rds_q   <= a_rds_d;
      a_ovh_q   <= a_ovh_d;
    end
    if (b_ready && a_valid_q) begin
      b_diff_q   <= b_diff_d;
      b_spc_q    <= a_spc_q;
      b_layout_q <= b_layout_d;
    end
  end

  assign out_valid_o  = b_valid_q;
  assign out_diff_o   = b_diff_q;
  assign out_spc_o    = b_spc_q;
  assign out_layout_o = b_layout_q;

endmodule

/* hdl/fbsc_div.sv */
// ---------------------------------------------------------------------------
// fbsc_div
// Pipelined restoring divider, 32-bit by 8-bit, a group of quotient bits
// per stage, with the layout carried alongside.
// ---------------------------------------------------------------------------
module fbsc_div import fbsc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [TotalWidth-1:0]   in_dividend_i,
  input  logic [DivisorWidth-1:0] in_divisor_i,
  input  fbsc_layout_t            in_layout_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [TotalWidth-1:0]   out_quotient_o,
  output fbsc_layout_t            out_layout_o
);

  logic [DivStages:0]      v_w;
  logic [DivStages:0]      rdy_w;
  logic [TotalWidth-1:0]   num_w [DivStages+1];
  logic [DivisorWidth-1:0] rem_w [DivStages+1];
  logic [DivisorWidth-1:0] dvs_w [DivStages+1];
  fbsc_layout_t            lay_w [DivStages+1];

  assign v_w[0]   = in_valid_i;
  assign num_w[0] = in_dividend_i;
  assign rem_w[0] = '0;
  assign dvs_w[0] = in_divisor_i;
  assign lay_w[0] = in_layout_i;
  assign rdy_w[DivStages] = out_ready_i;
  assign in_ready_o = rdy_w[0];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic                    valid_q;
    logic [TotalWidth-1:0]   num_q, num_d;
    logic [DivisorWidth-1:0] rem_q, rem_d;
    logic [DivisorWidth-1:0] dvs_q;
    fbsc_layout_t            lay_q;

    // quotient bits shift into the low end as dividend bits leave the top
    always_comb begin
      logic [DivisorWidth:0] trial;
      num_d = num_w[s];
      rem_d = rem_w[s];
      for (int b = 0; b < DivBits; b++) begin
        trial = {rem_d, num_d[TotalWidth-1]};
        num_d = {num_d[TotalWidth-2:0], 1'b0};
        if (trial >= {1'b0, dvs_w[s]}) begin
          rem_d    = DivisorWidth'(trial - {1'b0, dvs_w[s]});
          num_d[0] = 1'b1;
        end else begin
          rem_d = trial[DivisorWidth-1:0];
        end
      end
    end

    assign rdy_w[s] = !valid_q || rdy_w[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (rdy_w[s]) begin
        valid_q <= v_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy_w[s] && v_w[s]) begin
        num_q <= num_d;
        rem_q <= rem_d;
        dvs_q <= dvs_w[s];
        lay_q <= lay_w[s];
      end
    end

    assign v_w[s+1]   = valid_q;
    assign num_w[s+1] = num_q;
    assign rem_w[s+1] = rem_q;
    assign dvs_w[s+1] = dvs_q;
    assign lay_w[s+1] = lay_q;
  end

  assign out_valid_o    = v_w[DivStages];
  assign out_quotient_o = num_w[DivStages];
  assign out_layout_o   = lay_w[DivStages];

endmodule

/* dv/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for fat16_boot_sector_check_core.
// ---------------------------------------------------------------------------
// Sends boot sector beats: first hand-picked cases at the edges of every
// check, then random volumes. Most random volumes are well formed, some with
// cluster counts close to the limits. The rest have one field broken or are
// plain noise. Each accepted beat is predicted in the bench and queued. Each
// result beat is compared field by field against the oldest prediction.
// Both sides add random gaps, and one phase runs with no gaps at all.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbsc_pkg::*;

  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 10;
  localparam int DrainCycles = 16;
  localparam int CycleLimit  = 400000;
  // valid label except for the type digits
  localparam logic [63:0] LabelFat32 = 64'h2020_2032_3354_4146;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  fbsc_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  fbsc_out_t out_data_o;

  fbsc_out_t pending_layouts[$];
  int        err_cnt      = 0;
  int        beats_sent   = 0;
  int        valid_seen   = 0;
  int        invalid_seen = 0;
  int        cycle_cnt    = 0;
  int        hold_cnt     = 0;
  bit        burst_mode   = 1'b0;

  fat16_boot_sector_check_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // layout prediction
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] overhead_of(fbsc_in_t b);
    logic [31:0] root_secs;
    root_secs = (32'(b.root_entries) * 32'd32) / 32'd512;
    return 32'(b.rsvd_secs) + 32'(b.fat_copies) * 32'(b.sectors_per_fat) + root_secs;
  endfunction

  function automatic fbsc_out_t predict_layout(fbsc_in_t b);
    fbsc_out_t   r;
    logic        ok;
    logic [31:0] total;
    logic [31:0] overhead;
    logic [31:0] clusters;
    ok = (b.sector_size == SectorBytes) && (b.cluster_secs != 8'd0) &&
         (b.root_entries != 16'd0) && (b.fat_copies != 8'd0) && (b.fat_copies <= 8'd2) &&
         (b.sectors_per_fat != 16'd0) &&
         ((b.type_label == LabelFat16) || (b.type_label == LabelFat12));
    total    = (b.small_total != 16'd0) ? 32'(b.small_total) : b.large_total;
    overhead = overhead_of(b);
    clusters = '0;
    if (total == 32'd0) ok = 1'b0;
    if (ok) begin
      if (overhead >= total) begin
        ok = 1'b0;
      end else begin
        clusters = (total - overhead) / 32'(b.cluster_secs);
        if (clusters < MinClusters || clusters >= ClusterLimit) ok = 1'b0;
      end
    end
    r = '0;
    r.status = ~ok;
    if (ok) begin
      r.fat_start_sector      = b.rsvd_secs;
      r.root_dir_sector_count = 12'((32'(b.root_entries) * 32'd32) / 32'd512);
      r.first_data_sector     = overhead[17:0];
      r.cluster_count         = clusters[15:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic fbsc_in_t base_volume();
    fbsc_in_t b;
    b.sector_size     = SectorBytes;
    b.cluster_secs    = 8'd4;
    b.rsvd_secs       = 16'd1;
    b.fat_copies      = 8'd2;
    b.root_entries    = 16'd512;
    b.small_total     = 16'd40097;   // 10000 clusters
    b.large_total     = 32'd0;
    b.sectors_per_fat = 16'd32;
    b.type_label      = LabelFat16;
    return b;
  endfunction

  // small field when it fits and a coin says so, else the 32-bit one
  function automatic fbsc_in_t with_total(fbsc_in_t b, logic [31:0] total, bit allow_small);
    if (allow_small && total != 32'd0 && total < 32'h10000 && $urandom_range(0, 1) == 1) begin
      b.small_total = total[15:0];
      b.large_total = $urandom;
    end else begin
      b.small_total = 16'd0;
      b.large_total = total;
    end
    return b;
  endfunction

  function automatic fbsc_in_t random_volume();
    fbsc_in_t    b;
    logic [31:0] overhead;
    logic [31:0] clusters;
    logic [31:0] spc;
    int unsigned roll;
    b = base_volume();
    b.cluster_secs     = ($urandom_range(0, 1) == 1) ? 8'(1 << $urandom_range(0, 7))
                                                     : 8'($urandom_range(1, 255));
    b.rsvd_secs        = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 64))
                                                     : 16'($urandom);
    b.fat_copies       = 8'($urandom_range(1, 2));
    b.root_entries     = ($urandom_range(0, 1) == 1) ? 16'd512 : 16'($urandom_range(1, 65535));
    b.sectors_per_fat  = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(1, 256))
                                                     : 16'($urandom_range(1, 65535));
    b.type_label       = ($urandom_range(0, 1) == 1) ? LabelFat16 : LabelFat12;
    overhead = overhead_of(b);
    spc      = 32'(b.cluster_secs);
    roll     = $urandom_range(0, 99);
    if (roll < 10) begin
      // data region empty or negative
      return with_total(b, overhead - 32'($urandom_range(0, 2)), 1'b1);
    end
    if (roll < 25)      clusters = 32'($urandom_range(4083, 4087));
    else if (roll < 40) clusters = 32'($urandom_range(65522, 65527));
    else                clusters = 32'($urandom_range(3500, 70000));
    return with_total(b, overhead + clusters * spc + 32'($urandom_range(0, spc - 1)), 1'b1);
  endfunction

  function automatic fbsc_in_t broken_volume();
    fbsc_in_t b;
    b = random_volume();
    case ($urandom_range(0, 7))
      0: b.sector_size     = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'd256;
      1: b.cluster_secs    = 8'd0;
      2: b.root_entries    = 16'd0;
      3: b.fat_copies      = ($urandom_range(0, 1) == 1) ? 8'd0 : 8'($urandom_range(3, 255));
      4: b.sectors_per_fat = 16'd0;
      5: b.type_label[$urandom_range(0, 63)] ^= 1'b1;
      6: begin
        b.small_total = 16'd0;
        b.large_total = 32'd0;
      end
      default: begin
        b.small_total = 16'd0;
        b.large_total = $urandom;
      end
    endcase
    return b;
  endfunction

  function automatic fbsc_in_t noise_volume();
    fbsc_in_t b;
    b.sector_size     = 16'($urandom);
    b.cluster_secs    = 8'($urandom);
    b.rsvd_secs       = 16'($urandom);
    b.fat_copies      = 8'($urandom);
    b.root_entries    = 16'($urandom);
    b.small_total     = 16'($urandom);
    b.large_total     = $urandom;
    b.sectors_per_fat = 16'($urandom);
    b.type_label      = {$urandom, $urandom};
    return b;
  endfunction

  function automatic int draw_gap();
    int unsigned roll;
    if (burst_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // called at a rising edge, returns at the edge that takes the beat
  task automatic send_beat(input fbsc_in_t beat);
    int   gap;
    logic stalled;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    pending_layouts.insert(pending_layouts.size(), predict_layout(beat));
    beats_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, checks sampled before the taking edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : stall_gen
    int unsigned roll;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (burst_mode) begin
      out_stall_i <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        out_stall_i <= 1'b0;
        hold_cnt    <= $urandom_range(0, 15);
      end else if (roll < 90) begin
        out_stall_i <= 1'b1;
        hold_cnt    <= $urandom_range(0, 2);
      end else if (roll < 97) begin
        out_stall_i <= 1'b1;
        hold_cnt    <= $urandom_range(3, 10);
      end else begin
        out_stall_i <= 1'b1;
        hold_cnt    <= $urandom_range(20, 60);
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
    if (actv !== expv) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
      err_cnt++;
    end
  endtask

  always @(negedge clk_i) begin : result_check
    fbsc_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_layouts.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h", $time, out_data_o);
        err_cnt++;
      end else begin
        want = pending_layouts.pop_front();
        compare_field("status", 32'(want.status), 32'(out_data_o.status));
        compare_field("fat_start_sector", 32'(want.fat_start_sector),
                      32'(out_data_o.fat_start_sector));
        compare_field("root_dir_sector_count", 32'(want.root_dir_sector_count),
                      32'(out_data_o.root_dir_sector_count));
        compare_field("first_data_sector", 32'(want.first_data_sector),
                      32'(out_data_o.first_data_sector));
        compare_field("cluster_count", 32'(want.cluster_count),
                      32'(out_data_o.cluster_count));
        if (want.status) invalid_seen++;
        else             valid_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_valid_layouts();
    fbsc_in_t b;
    send_beat(base_volume());
    b = base_volume();
    b.type_label = LabelFat12;
    send_beat(b);
    // largest possible overhead, one sector per cluster
    b = base_volume();
    b.rsvd_secs       = 16'hFFFF;
    b.sectors_per_fat = 16'hFFFF;
    b.root_entries    = 16'hFFFF;
    b.cluster_secs    = 8'd1;
    send_beat(with_total(b, overhead_of(b) + 32'd65524, 1'b0));
    // widest clusters
    b = base_volume();
    b.cluster_secs = 8'd255;
    send_beat(with_total(b, overhead_of(b) + 32'd4085 * 32'd255 + 32'd254, 1'b0));
  endtask

  task automatic test_field_rejects();
    fbsc_in_t b;
    b = base_volume();
    b.sector_size = 16'd0;
    send_beat(b);
    b.sector_size = 16'hFFFF;
    send_beat(b);
    b = base_volume();
    b.cluster_secs = 8'd0;
    send_beat(b);
    b = base_volume();
    b.root_entries = 16'd0;
    send_beat(b);
    b = base_volume();
    b.fat_copies = 8'd0;
    send_beat(b);
    b.fat_copies = 8'd3;
    send_beat(b);
    b.fat_copies = 8'hFF;
    send_beat(b);
    b = base_volume();
    b.sectors_per_fat = 16'd0;
    send_beat(b);
    b = base_volume();
    b.type_label = '0;
    send_beat(b);
    b.type_label = '1;
    send_beat(b);
    b.type_label = LabelFat32;
    send_beat(b);
  endtask

  task automatic test_total_selection();
    fbsc_in_t b;
    b = base_volume();
    b.small_total = 16'd0;
    b.large_total = 32'd40097;
    send_beat(b);
    b.large_total = 32'd0;
    send_beat(b);
    // large count ignored while the small one is set
    b.small_total = 16'd40097;
    b.large_total = 32'hFFFF_FFFF;
    send_beat(b);
    b.small_total = 16'd0;
    send_beat(b);
  endtask

  task automatic test_cluster_bounds();
    fbsc_in_t    b;
    logic [31:0] ovh;
    b   = base_volume();
    ovh = overhead_of(b);
    send_beat(with_total(b, ovh + 32'd4 * 32'd4084 + 32'd3, 1'b0));
    send_beat(with_total(b, ovh + 32'd4 * 32'd4085, 1'b0));
    send_beat(with_total(b, ovh + 32'd4 * 32'd65524 + 32'd3, 1'b0));
    send_beat(with_total(b, ovh + 32'd4 * 32'd65525, 1'b0));
    b.small_total = ovh[15:0];
    send_beat(b);
    b.small_total = ovh[15:0] - 16'd1;
    send_beat(b);
  endtask

  task automatic test_random_volumes(input int count);
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)      send_beat(random_volume());
      else if (roll < 85) send_beat(broken_volume());
      else                send_beat(noise_volume());
    end
  endtask

  task automatic test_back_to_back(input int count);
    burst_mode = 1'b1;
    test_random_volumes(count);
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_valid_layouts();
    test_field_rejects();
    test_total_selection();
    test_cluster_bounds();
    test_random_volumes(300);
    test_back_to_back(60);
    test_random_volumes(90);
    in_valid_i <= 1'b0;
    while (pending_layouts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d boot sector beats: %0d accepted volumes, %0d rejected",
             beats_sent, valid_seen, invalid_seen);
    $display("covered field rejects, total selection, cluster limits, random and burst traffic");
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/fbsc_pkg.sv
hdl/fbsc_front.sv
hdl/fbsc_div.sv
hdl/fat16_boot_sector_check_core.sv
dv/tb.sv
